// ===== rtl/stable_sorted_priority_queue_unit_defines.svh =====
// assertion macros for the stable sorted priority queue unit
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SSPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sspq_pkg.sv =====
// shared constants, codes and types of the sorted priority queue
`timescale 1ns / 1ps
package sspq_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int PRIO_BITS = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic [ELEM_BITS-1:0] new_elem;
    logic [PRIO_BITS-1:0] new_prio;
  } cell_ctrl_t;

endpackage

// ===== rtl/sspq_cell.sv =====
// one slot of the sorted chain: holds an entry, compares, shifts
`timescale 1ns / 1ps
module sspq_cell (
  input  logic                          clk,
  input  sspq_pkg::cell_ctrl_t          ctrl,
  input  logic                          occ,
  input  logic                          left_ins,
  input  logic [sspq_pkg::ELEM_BITS-1:0] left_elem,
  input  logic [sspq_pkg::PRIO_BITS-1:0] left_prio,
  input  logic [sspq_pkg::ELEM_BITS-1:0] right_elem,
  input  logic [sspq_pkg::PRIO_BITS-1:0] right_prio,
  output logic                          ins,
  output logic [sspq_pkg::ELEM_BITS-1:0] slot_elem,
  output logic [sspq_pkg::PRIO_BITS-1:0] slot_prio,
  output logic [sspq_pkg::ELEM_BITS-1:0] elem_nxt,
  output logic [sspq_pkg::PRIO_BITS-1:0] prio_nxt
);
  import sspq_pkg::*;

  logic [ELEM_BITS-1:0] elem_r;
  logic [PRIO_BITS-1:0] prio_r;

  // new entry lands at or before this slot (strictly greater keeps fifo order)
  assign ins = !occ || (prio_r > ctrl.new_prio);

  always_comb begin
    elem_nxt = elem_r;
    prio_nxt = prio_r;
    if (ctrl.enq) begin
      if (left_ins) begin
        elem_nxt = left_elem;
        prio_nxt = left_prio;
      end else if (ins) begin
        elem_nxt = ctrl.new_elem;
        prio_nxt = ctrl.new_prio;
      end
    end else if (ctrl.deq) begin
      elem_nxt = right_elem;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    prio_r <= prio_nxt;
  end

  assign slot_elem = elem_r;
  assign slot_prio = prio_r;

endmodule

// ===== rtl/stable_sorted_priority_queue_unit.sv =====
// top level: sorted chain of slots, occupancy count and result register
// the result of a transfer is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while results are taken as they appear
// every slot compares with the new priority and shifts in the same cycle
// reset clears the count and the result valid; slot contents are left as is
`timescale 1ns / 1ps
module stable_sorted_priority_queue_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [sspq_pkg::ELEM_BITS-1:0] in_elem_value,
  input  logic [sspq_pkg::PRIO_BITS-1:0] in_prio_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sspq_pkg::ELEM_BITS-1:0] out_head_elem,
  output logic [sspq_pkg::PRIO_BITS-1:0] out_head_prio,
  output logic [sspq_pkg::CNT_BITS-1:0]  out_entry_count,
  output logic                           out_queue_empty,
  output logic                           out_is_full,
  output logic [1:0]                     out_status
);
  import sspq_pkg::*;

  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                accept;
  logic                q_full, q_empty;
  cell_ctrl_t          ctrl;
  status_t             status_nxt;

  // chain wiring, one entry per slot
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  ins;
  logic [ELEM_BITS-1:0] slot_elem [CAPACITY];
  logic [PRIO_BITS-1:0] slot_prio [CAPACITY];
  logic [ELEM_BITS-1:0] elem_nxt  [CAPACITY];
  logic [PRIO_BITS-1:0] prio_nxt  [CAPACITY];

  // result register
  logic                 out_valid_r;
  logic [ELEM_BITS-1:0] head_elem_r;
  logic [PRIO_BITS-1:0] head_prio_r;
  logic [CNT_BITS-1:0]  cnt_out_r;
  logic                 empty_r, full_r;
  status_t              status_r;

  // a new item may enter whenever the result slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign q_full  = (count_r == CNT_BITS'(CAPACITY));
  assign q_empty = (count_r == '0);

  always_comb begin
    ctrl.enq      = accept && (in_mode == MODE_ENQ) && !q_full;
    ctrl.deq      = accept && (in_mode == MODE_DEQ) && !q_empty;
    ctrl.new_elem = in_elem_value;
    ctrl.new_prio = in_prio_value;
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
    // rejected requests leave the queue untouched and are flagged
    if (in_mode == MODE_ENQ && q_full) begin
      status_nxt = STATUS_FULL;
    end else if (in_mode == MODE_DEQ && q_empty) begin
      status_nxt = STATUS_EMPTY;
    end
  end

  // the chain of slots; slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic                 l_ins;
    logic [ELEM_BITS-1:0] l_elem, r_elem;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    // slot is live when it sits below the fill count
    assign occ[i] = (CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_first
      assign l_ins  = 1'b0;
      assign l_elem = slot_elem[i];
      assign l_prio = slot_prio[i];
    end else begin : g_mid
      assign l_ins  = ins[i-1];
      assign l_elem = slot_elem[i-1];
      assign l_prio = slot_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_elem = slot_elem[i];
      assign r_prio = slot_prio[i];
    end else begin : g_inner
      assign r_elem = slot_elem[i+1];
      assign r_prio = slot_prio[i+1];
    end

    sspq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .left_ins   (l_ins),
      .left_elem  (l_elem),
      .left_prio  (l_prio),
      .right_elem (r_elem),
      .right_prio (r_prio),
      .ins        (ins[i]),
      .slot_elem  (slot_elem[i]),
      .slot_prio  (slot_prio[i]),
      .elem_nxt   (elem_nxt[i]),
      .prio_nxt   (prio_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload captures the state after this step
  always_ff @(posedge clk) begin
    if (accept) begin
      head_elem_r <= (count_nxt != '0) ? elem_nxt[0] : '0;
      head_prio_r <= (count_nxt != '0) ? prio_nxt[0] : '0;
      cnt_out_r   <= count_nxt;
      empty_r     <= (count_nxt == '0);
      full_r      <= (count_nxt == CNT_BITS'(CAPACITY));
      status_r    <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_elem   = head_elem_r;
  assign out_head_prio   = head_prio_r;
  assign out_entry_count = cnt_out_r;
  assign out_queue_empty = empty_r;
  assign out_is_full     = full_r;
  assign out_status      = status_r;

endmodule

// ===== rtl/sspq_checker.sv =====
// port-level checks of the sorted priority queue unit, bound to the top level
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_unit_defines.svh"
module sspq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sspq_pkg::ELEM_BITS-1:0] out_head_elem,
  input logic [sspq_pkg::PRIO_BITS-1:0] out_head_prio,
  input logic [sspq_pkg::CNT_BITS-1:0]  out_entry_count,
  input logic                           out_queue_empty,
  input logic                           out_is_full,
  input logic [1:0]                     out_status
);
  import sspq_pkg::*;

  localparam int RESULT_BITS = ELEM_BITS + PRIO_BITS + CNT_BITS + 4;

  logic                   stalled;
  logic [RESULT_BITS-1:0] result_word;
  logic                   rejected;
  logic                   reject_fill_ok;
  logic                   count_zero;
  logic                   count_full;
  logic                   head_zero;

  assign stalled     = out_valid && !out_ready;
  assign result_word = {out_head_elem, out_head_prio, out_entry_count,
                        out_queue_empty, out_is_full, out_status};
  assign rejected    = (out_status == STATUS_FULL) || (out_status == STATUS_EMPTY);
  assign reject_fill_ok = (out_status == STATUS_FULL && out_is_full) ||
                          (out_status == STATUS_EMPTY && out_queue_empty);
  assign count_zero  = (out_entry_count == '0);
  assign count_full  = (out_entry_count == CNT_BITS'(CAPACITY));
  assign head_zero   = (out_head_elem == '0) && (out_head_prio == '0);

  `SSPQ_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(result_word), "stalled result changed")
  `SSPQ_ASSERT_IMPL(a_empty_flag, out_valid, out_queue_empty == count_zero, "empty flag off")
  `SSPQ_ASSERT_IMPL(a_full_flag, out_valid, out_is_full == count_full, "full flag off")
  `SSPQ_ASSERT_IMPL(a_empty_head, out_valid && out_queue_empty, head_zero, "empty queue shows a head")
  `SSPQ_ASSERT_IMPL(a_reject_flag, out_valid && rejected, reject_fill_ok, "bad reject fill state")

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_head_elem   (out_head_elem),
  .out_head_prio   (out_head_prio),
  .out_entry_count (out_entry_count),
  .out_queue_empty (out_queue_empty),
  .out_is_full     (out_is_full),
  .out_status      (out_status)
);
